FILE: design/ffs_pkg.sv
// ----------------------------------------------------------------------------
// Format specifier scanner package
// Shared constants, byte classes, scan phases and queue entry types.
// ----------------------------------------------------------------------------
package ffs_pkg;

  // Longest string that can be valid, and the position counter that covers it.
  localparam int unsigned MAX_LEN       = 4096;
  localparam int unsigned POS_W         = $clog2(MAX_LEN + 1);

  // Field widths of the channels.
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SPAN_BEGIN_W  = 12;
  localparam int unsigned SPAN_FINISH_W = 13;
  localparam int unsigned CODE_W        = 3;
  localparam int unsigned DIGITS_W      = 7;

  // Scan arithmetic.
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned RUN_W         = 8;
  localparam int unsigned RUN_LIMIT     = 128;
  localparam int unsigned RUN_CALC_W    = RUN_W + DIGIT_W;
  localparam int unsigned PREC_CALC_W   = DIGITS_W + DIGIT_W;
  localparam int unsigned COUNT_W       = 2;
  localparam int unsigned COUNT_SAT     = 2;

  // Queue between the classifier and the scanner.
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic [DIGITS_W-1:0] MAX_DIGITS_RST = 7'd17;
  localparam logic [DIGITS_W-1:0] MIN_DIGITS_RST = 7'd6;

  // Characters the scanner recognizes.
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PERIOD  = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LC_E    = 8'h65;
  localparam logic [BYTE_W-1:0] CH_UC_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CH_LC_F    = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LC_G    = 8'h67;
  localparam logic [BYTE_W-1:0] CH_UC_G    = 8'h47;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_MAX_DIGITS = 1'b0,
    REG_MIN_DIGITS = 1'b1
  } reg_idx_e;

  // Conversion letter codes.
  typedef enum logic [CODE_W-1:0] {
    CONV_LC_E = 3'd0,
    CONV_UC_E = 3'd1,
    CONV_LC_F = 3'd2,
    CONV_LC_G = 3'd3,
    CONV_UC_G = 3'd4
  } conv_e;

  // Scan phases.
  typedef enum logic [2:0] {
    PH_LIT   = 3'd0,
    PH_PCT   = 3'd1,
    PH_FLAGS = 3'd2,
    PH_WIDTH = 3'd3,
    PH_PREC  = 3'd4
  } phase_e;

  // What one byte is, as far as the scanner cares.
  typedef struct packed {
    logic                pct;
    logic                letter;
    logic                flag;
    logic                digit;
    logic                period;
    conv_e               code;
    logic [DIGIT_W-1:0]  dval;
  } byte_class_t;

  // One classified byte waiting for the scanner.
  typedef struct packed {
    byte_class_t         cls;
    logic                last;
    logic                too_long;
    logic [POS_W-1:0]    pos;
  } qentry_t;

  // Configuration register contents.
  typedef struct packed {
    logic [DIGITS_W-1:0] max_digits;
    logic [DIGITS_W-1:0] min_digits;
  } cfg_t;

  // Sort one byte into the classes above. A '0' is both a flag and a digit.
  function automatic byte_class_t classify(logic [BYTE_W-1:0] c);
    byte_class_t cls;
    cls        = '0;
    cls.code   = CONV_LC_E;
    cls.pct    = (c == CH_PERCENT);
    cls.flag   = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_ZERO) ||
                 (c == CH_SPACE) || (c == CH_HASH);
    cls.digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    cls.period = (c == CH_PERIOD);
    cls.dval   = c[DIGIT_W-1:0];
    unique case (c)
      CH_LC_E: begin
        cls.letter = 1'b1;
        cls.code   = CONV_LC_E;
      end
      CH_UC_E: begin
        cls.letter = 1'b1;
        cls.code   = CONV_UC_E;
      end
      CH_LC_F: begin
        cls.letter = 1'b1;
        cls.code   = CONV_LC_F;
      end
      CH_LC_G: begin
        cls.letter = 1'b1;
        cls.code   = CONV_LC_G;
      end
      CH_UC_G: begin
        cls.letter = 1'b1;
        cls.code   = CONV_UC_G;
      end
      default: begin
        cls.letter = 1'b0;
      end
    endcase
    return cls;
  endfunction

endpackage

FILE: design/ffs_in_if.sv
// ----------------------------------------------------------------------------
// Format byte channel
// Valid/ready channel that carries one byte of a format string per transfer.
// ----------------------------------------------------------------------------
interface ffs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ffs_pkg::BYTE_W-1:0]  format_byte;
  logic                        last_byte;

  modport source (output valid, output format_byte, output last_byte, input ready);
  modport sink (input valid, input format_byte, input last_byte, output ready);
  modport monitor (input valid, input ready, input format_byte, input last_byte);
endinterface

FILE: design/ffs_out_if.sv
// ----------------------------------------------------------------------------
// Scan result channel
// Valid/ready channel that carries one scan result per string.
// ----------------------------------------------------------------------------
interface ffs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               valid_res;
  logic [ffs_pkg::SPAN_BEGIN_W-1:0]   span_begin;
  logic [ffs_pkg::SPAN_FINISH_W-1:0]  span_finish;
  logic [ffs_pkg::CODE_W-1:0]         conversion_code;
  logic                               precision_given;
  logic [ffs_pkg::DIGITS_W-1:0]       digits;
  logic                               oversize;

  modport source (
    output valid, output valid_res, output span_begin, output span_finish,
    output conversion_code, output precision_given, output digits, output oversize,
    input  ready
  );
  modport sink (
    input  valid, input valid_res, input span_begin, input span_finish,
    input  conversion_code, input precision_given, input digits, input oversize,
    output ready
  );
  modport monitor (
    input valid, input ready, input valid_res, input span_begin, input span_finish,
    input conversion_code, input precision_given, input digits, input oversize
  );
endinterface

FILE: design/float_format_specifier_scanner.sv
// ----------------------------------------------------------------------------
// Float format specifier scanner
// Byte-serial scanner that checks a printf-style string for exactly one
// floating conversion and reports its span, letter and precision.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one byte of the format string per transfer, with last_byte
//   set on the final byte. Empty strings are not sent. out_o carries one
//   result per string, produced by the transfer of its last byte.
//   The APB port holds max_digits (address 0) and min_digits (address 4);
//   write them only while no string is in flight.
// Throughput and result path:
//   One byte is taken every cycle while the byte queue has room. The last
//   byte passes through the four-entry byte queue between the classifier and
//   the scanner state machine, and then fills the single result register once
//   the result slot is free; the result is then shown on out_o.
// Reset:
//   The scan restarts in the literal text phase, the queue and result slot
//   are emptied, and the registers return to 17 and 6.
// Stalls:
//   While a result waits on out_o, later non-last bytes are still scanned;
//   the next last byte waits in the queue, which then fills and drops ready.
// ----------------------------------------------------------------------------
module float_format_specifier_scanner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ffs_in_if.sink                            in_i,
  ffs_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ffs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ffs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ffs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     q_push, q_full, q_pop, q_empty;
  qentry_t  q_wr_entry, q_rd_entry;

  // Configuration registers, decoded by word address.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_digits <= MAX_DIGITS_RST;
      cfg_q.min_digits <= MIN_DIGITS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_DIGITS: cfg_q.max_digits <= pwdata[DIGITS_W-1:0];
        REG_MIN_DIGITS: cfg_q.min_digits <= pwdata[DIGITS_W-1:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_MAX_DIGITS: prdata = APB_DATA_W'(cfg_q.max_digits);
      REG_MIN_DIGITS: prdata = APB_DATA_W'(cfg_q.min_digits);
    endcase
  end

  // Classifier front end.
  ffs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  // Byte queue.
  ffs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  // Scanner back end.
  ffs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_entry_i (q_rd_entry),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_q),
    .out_o     (out_o)
  );

endmodule

FILE: design/ffs_front.sv
// ----------------------------------------------------------------------------
// Format scanner front end
// Accepts bytes, classifies them, tracks the byte position within the
// string and pushes each classified byte into the queue.
// ----------------------------------------------------------------------------
module ffs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ffs_in_if.sink           in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ffs_pkg::qentry_t q_entry_o
);
  import ffs_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             too_long;

  // A byte is taken whenever the queue has room.
  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && in_i.ready;

  // Bytes at or beyond the length limit make the string invalid.
  assign too_long = (pos_q >= POS_W'(MAX_LEN));

  // Position counter saturates at the limit and restarts after the last byte.
  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      if (in_i.last_byte) begin
        pos_d = '0;
      end else if (!too_long) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Queue entry for the scanner.
  always_comb begin
    q_entry_o.cls      = classify(in_i.format_byte);
    q_entry_o.last     = in_i.last_byte;
    q_entry_o.too_long = too_long;
    q_entry_o.pos      = pos_q;
  end

endmodule

FILE: design/ffs_queue.sv
// ----------------------------------------------------------------------------
// Format scanner queue
// Small first-in first-out buffer of classified bytes between the front
// end and the scanner.
// ----------------------------------------------------------------------------
module ffs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ffs_pkg::qentry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output ffs_pkg::qentry_t entry_o,
  output logic             empty_o
);
  import ffs_pkg::*;

  qentry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/ffs_back.sv
// ----------------------------------------------------------------------------
// Format scanner back end
// Runs the specifier state machine over classified bytes, keeps the data
// of the first conversion and registers one result per string.
// ----------------------------------------------------------------------------
module ffs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  ffs_pkg::qentry_t q_entry_i,
  output logic             q_pop_o,
  input  ffs_pkg::cfg_t    cfg_i,
  ffs_out_if.source        out_o
);
  import ffs_pkg::*;

  // Scan state.
  phase_e                    phase_q, phase_d, phase_nx, phase_eff;
  logic [COUNT_W-1:0]        count_q, count_nx;
  logic                      err_q, err_nx;
  logic [SPAN_BEGIN_W-1:0]   begin_q, begin_nx;
  logic [SPAN_FINISH_W-1:0]  finish_q, finish_nx;
  conv_e                     code_q, code_nx;
  logic [DIGITS_W-1:0]       prec_q, prec_nx;
  logic                      period_q, period_nx;
  logic [RUN_W-1:0]          run_q, run_nx;
  logic                      ovs_q, ovs_nx;

  // Per-byte decode.
  byte_class_t               cls;
  logic                      bad;
  logic                      pair;
  logic                      body;
  logic                      first;
  logic [RUN_CALC_W-1:0]     run_calc;
  logic                      run_sat;
  logic [PREC_CALC_W-1:0]    prec_calc;
  logic                      res_valid;

  // Output register.
  logic                      slot_free;
  logic                      out_valid_q, out_valid_d;
  logic                      res_valid_q;
  logic [SPAN_BEGIN_W-1:0]   res_begin_q;
  logic [SPAN_FINISH_W-1:0]  res_finish_q;
  logic [CODE_W-1:0]         res_code_q;
  logic                      res_period_q;
  logic [DIGITS_W-1:0]       res_digits_q;
  logic                      res_ovs_q;

  assign cls = q_entry_i.cls;

  // Non-last bytes never wait; the last byte waits for a free result slot.
  assign slot_free = !out_valid_q || out_o.ready;
  assign q_pop_o   = !q_empty_i && (!q_entry_i.last || slot_free);

  // Next phase of the specifier state machine.
  always_comb begin
    phase_eff = (phase_q == PH_PCT) ? PH_FLAGS : phase_q;
    phase_nx  = phase_q;
    bad       = 1'b0;
    unique case (phase_q)
      PH_LIT: begin
        if (cls.pct) begin
          phase_nx = PH_PCT;
        end
      end
      default: begin
        priority if (phase_q == PH_PCT && cls.pct) begin
          phase_nx = PH_LIT;
        end else if (cls.letter) begin
          phase_nx = PH_LIT;
        end else if (phase_eff == PH_FLAGS && cls.flag) begin
          phase_nx = PH_FLAGS;
        end else if ((phase_eff == PH_FLAGS || phase_eff == PH_WIDTH) && cls.digit) begin
          phase_nx = PH_WIDTH;
        end else if ((phase_eff == PH_FLAGS || phase_eff == PH_WIDTH) && cls.period) begin
          phase_nx = PH_PREC;
        end else if (phase_eff == PH_PREC && cls.digit) begin
          phase_nx = PH_PREC;
        end else begin
          phase_nx = PH_LIT;
          bad      = 1'b1;
        end
      end
    endcase
    phase_d = q_pop_o ? (q_entry_i.last ? PH_LIT : phase_nx) : phase_q;
  end

  // Digit accumulators: run*10+d and precision*10+d.
  always_comb begin
    run_calc  = (RUN_CALC_W'(run_q) << 3) + (RUN_CALC_W'(run_q) << 1) +
                RUN_CALC_W'(cls.dval);
    run_sat   = (run_calc >= RUN_CALC_W'(RUN_LIMIT));
    prec_calc = (PREC_CALC_W'(prec_q) << 3) + (PREC_CALC_W'(prec_q) << 1) +
                PREC_CALC_W'(cls.dval);
  end

  // Data kept for the first conversion, and the string verdict.
  always_comb begin
    pair      = (phase_q == PH_PCT) && cls.pct;
    body      = (phase_q != PH_LIT) && !pair;
    first     = (count_q == '0);
    count_nx  = count_q;
    begin_nx  = begin_q;
    finish_nx = finish_q;
    code_nx   = code_q;
    prec_nx   = prec_q;
    period_nx = period_q;
    run_nx    = run_q;
    ovs_nx    = ovs_q;
    err_nx    = err_q || q_entry_i.too_long || bad;

    // A percent sign opens a conversion candidate.
    if (phase_q == PH_LIT && cls.pct && first) begin
      begin_nx  = q_entry_i.pos[SPAN_BEGIN_W-1:0];
      prec_nx   = '0;
      period_nx = 1'b0;
      run_nx    = '0;
      ovs_nx    = 1'b0;
    end

    // Track the current run of decimal digits.
    if (body && first) begin
      if (cls.digit) begin
        run_nx = run_sat ? RUN_W'(RUN_LIMIT) : run_calc[RUN_W-1:0];
        ovs_nx = ovs_q || run_sat;
      end else begin
        run_nx = '0;
      end
    end

    // A conversion letter closes the conversion.
    if (body && cls.letter) begin
      if (first) begin
        finish_nx = SPAN_FINISH_W'(q_entry_i.pos) + SPAN_FINISH_W'(1);
        code_nx   = cls.code;
      end
      if (count_q != COUNT_W'(COUNT_SAT)) begin
        count_nx = count_q + COUNT_W'(1);
      end
    end

    // The period opens the precision.
    if (body && first && cls.period &&
        (phase_eff == PH_FLAGS || phase_eff == PH_WIDTH)) begin
      period_nx = 1'b1;
    end

    // Precision digits saturate at the ceiling.
    if (body && first && cls.digit && phase_eff == PH_PREC) begin
      prec_nx = (prec_calc < PREC_CALC_W'(cfg_i.max_digits)) ?
                prec_calc[DIGITS_W-1:0] : cfg_i.max_digits;
    end

    res_valid = !err_nx && (phase_nx == PH_LIT) && (count_nx == COUNT_W'(1));
  end

  // Scan state registers; the last byte of a string restarts the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LIT;
      count_q  <= '0;
      err_q    <= 1'b0;
      begin_q  <= '0;
      finish_q <= '0;
      code_q   <= CONV_LC_E;
      prec_q   <= '0;
      period_q <= 1'b0;
      run_q    <= '0;
      ovs_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (q_pop_o) begin
        if (q_entry_i.last) begin
          count_q  <= '0;
          err_q    <= 1'b0;
          begin_q  <= '0;
          finish_q <= '0;
          code_q   <= CONV_LC_E;
          prec_q   <= '0;
          period_q <= 1'b0;
          run_q    <= '0;
          ovs_q    <= 1'b0;
        end else begin
          count_q  <= count_nx;
          err_q    <= err_nx;
          begin_q  <= begin_nx;
          finish_q <= finish_nx;
          code_q   <= code_nx;
          prec_q   <= prec_nx;
          period_q <= period_nx;
          run_q    <= run_nx;
          ovs_q    <= ovs_nx;
        end
      end
    end
  end

  // Result slot: filled on the last byte, emptied by an output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o && q_entry_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; an invalid string reports zeros and the default digits.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.last) begin
      res_valid_q  <= res_valid;
      res_begin_q  <= res_valid ? begin_nx : '0;
      res_finish_q <= res_valid ? finish_nx : '0;
      res_code_q   <= res_valid ? code_nx : CONV_LC_E;
      res_period_q <= res_valid && period_nx;
      res_digits_q <= (res_valid && period_nx) ? prec_nx : cfg_i.min_digits;
      res_ovs_q    <= res_valid && ovs_nx;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.valid_res       = res_valid_q;
  assign out_o.span_begin      = res_begin_q;
  assign out_o.span_finish     = res_finish_q;
  assign out_o.conversion_code = res_code_q;
  assign out_o.precision_given = res_period_q;
  assign out_o.digits          = res_digits_q;
  assign out_o.oversize        = res_ovs_q;

endmodule

FILE: design/ffs_checker.sv
// ----------------------------------------------------------------------------
// Format scanner port checker
// Concurrent checks on the byte and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module ffs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               out_valid_res_i,
  input logic [ffs_pkg::SPAN_BEGIN_W-1:0]   out_span_begin_i,
  input logic [ffs_pkg::SPAN_FINISH_W-1:0]  out_span_finish_i,
  input logic [ffs_pkg::CODE_W-1:0]         out_code_i,
  input logic                               out_precision_given_i,
  input logic [ffs_pkg::DIGITS_W-1:0]       out_digits_i,
  input logic                               out_oversize_i
);
  import ffs_pkg::*;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_valid_res_i) && $stable(out_span_begin_i) &&
      $stable(out_span_finish_i) && $stable(out_digits_i))
    else $error("result changed while stalled");

  // A rejected string reports no conversion data.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_valid_res_i |->
      out_span_begin_i == '0 && out_span_finish_i == '0 &&
      out_code_i == '0 && !out_precision_given_i && !out_oversize_i)
    else $error("invalid result carries conversion data");

  // An accepted conversion has a known letter and ends after it begins.
  a_valid_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_valid_res_i |->
      out_code_i <= CONV_UC_G &&
      out_span_finish_i > SPAN_FINISH_W'(out_span_begin_i))
    else $error("valid result with bad span or letter code");

  // Ready never drops without bytes having been taken before.
  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input stalled without prior transfer");

endmodule

bind float_format_specifier_scanner ffs_checker u_ffs_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_valid_res_i       (out_o.valid_res),
  .out_span_begin_i      (out_o.span_begin),
  .out_span_finish_i     (out_o.span_finish),
  .out_code_i            (out_o.conversion_code),
  .out_precision_given_i (out_o.precision_given),
  .out_digits_i          (out_o.digits),
  .out_oversize_i        (out_o.oversize)
);
